[hdl/md4_hash_engine_unit_macros.svh]
// ============================================================================
// MD4 hash engine assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ============================================================================
`ifndef MD4_HASH_ENGINE_UNIT_MACROS_SVH
`define MD4_HASH_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MD4_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MD4_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> nxt) else $error(msg);
`else
`define MD4_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define MD4_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg)
`endif
`endif

[hdl/md4_pkg.sv]
// ============================================================================
// MD4 package
// Types, constants and round helpers shared by the MD4 engine modules.
// ============================================================================
package md4_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] K2  = 32'h5a827999;
    localparam logic [31:0] K3  = 32'h6ed9eba1;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD,
        ST_PCOMP,
        ST_EMIT
    } t_state;

    // source of the byte written into the block buffer
    typedef enum logic [1:0] {
        BSEL_DATA,
        BSEL_PAD,
        BSEL_ZERO,
        BSEL_LEN
    } t_bsel;

    // controller to datapath
    typedef struct packed {
        logic        wr_en;
        t_bsel       bsel;
        logic        cnt_add;
        logic        start;
        logic        load_iv;
        logic        out_load;
        logic [1:0]  out_idx;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [5:0]  pos;
    } t_status;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] d;
        d = {x, x} << s;
        return d[63:32];
    endfunction

    function automatic logic [4:0] shift_amt(input logic [1:0] r, input logic [1:0] j);
        logic [4:0] s;
        case (r)
            2'd0: begin
                case (j)
                    2'd0: s = 5'd3;
                    2'd1: s = 5'd7;
                    2'd2: s = 5'd11;
                    default: s = 5'd19;
                endcase
            end
            2'd1: begin
                case (j)
                    2'd0: s = 5'd3;
                    2'd1: s = 5'd5;
                    2'd2: s = 5'd9;
                    default: s = 5'd13;
                endcase
            end
            default: begin
                case (j)
                    2'd0: s = 5'd3;
                    2'd1: s = 5'd9;
                    2'd2: s = 5'd11;
                    default: s = 5'd15;
                endcase
            end
        endcase
        return s;
    endfunction

    // message word index for round r, step i
    function automatic logic [3:0] msg_idx(input logic [1:0] r, input logic [3:0] i);
        logic [3:0] m;
        case (r)
            2'd0: m = i;
            2'd1: m = {i[1:0], i[3:2]};
            default: m = {i[0], i[1], i[2], i[3]};
        endcase
        return m;
    endfunction

endpackage

[hdl/md4_ctrl.sv]
// ============================================================================
// MD4 controller
// Sequences absorb, compression, padding and digest emission.
// ============================================================================
module md4_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_command,
    output logic               o_stall,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output md4_pkg::t_cmd      o_cmd,
    input  md4_pkg::t_status   i_status
);
    import md4_pkg::*;

    t_state     r_state, n_state;
    logic       r_fin, n_fin;        // length goes into the block being padded
    logic [1:0] r_oidx, n_oidx;
    logic       r_ov, n_ov;
    logic       acc;

    assign o_stall     = (r_state != ST_IDLE) || r_ov;
    assign acc         = i_valid && !o_stall;
    assign o_out_valid = r_ov;

    // next state
    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        n_oidx  = r_oidx;
        n_ov    = r_ov;
        if (r_ov && !i_out_stall) n_ov = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (i_command == CMD_FINISH) begin
                        // pad byte at 56 or later needs one more block
                        n_fin = (i_status.pos < LEN_POS);
                        n_state = (i_status.pos == 6'd63) ? ST_PCOMP : ST_PAD;
                    end else if (i_status.pos == 6'd63) begin
                        n_state = ST_COMP;
                    end
                end
            end
            ST_COMP: begin
                if (i_status.done) n_state = ST_IDLE;
            end
            ST_PAD: begin
                if (i_status.pos == 6'd63) n_state = ST_PCOMP;
            end
            ST_PCOMP: begin
                if (i_status.done) begin
                    if (r_fin) begin
                        n_state = ST_EMIT;
                        n_oidx  = 2'd0;
                    end else begin
                        n_fin   = 1'b1;
                        n_state = ST_PAD;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov   = 1'b1;
                    n_oidx = r_oidx + 2'd1;
                    if (r_oidx == 2'd3) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.bsel = BSEL_DATA;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.bsel    = (i_command == CMD_FINISH) ? BSEL_PAD : BSEL_DATA;
                    o_cmd.cnt_add = (i_command == CMD_ABSORB);
                    o_cmd.start   = (i_status.pos == 6'd63);
                end
            end
            ST_PAD: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.bsel  = (r_fin && i_status.pos >= LEN_POS) ? BSEL_LEN : BSEL_ZERO;
                o_cmd.start = (i_status.pos == 6'd63);
            end
            ST_EMIT: begin
                if (!r_ov || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_idx  = r_oidx;
                    o_cmd.load_iv  = (r_oidx == 2'd3);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fin   <= 1'b0;
            r_oidx  <= 2'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            r_oidx  <= n_oidx;
            r_ov    <= n_ov;
        end
    end

endmodule

[hdl/md4_datapath.sv]
// ============================================================================
// MD4 datapath
// Block buffer, bit counter, chaining words and the shared round unit.
// ============================================================================
module md4_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_data_byte,
    input  md4_pkg::t_cmd      i_cmd,
    output md4_pkg::t_status   o_status,
    output logic [31:0]        o_digest_word,
    output logic [1:0]         o_word_index,
    output logic               o_last_word
);
    import md4_pkg::*;

    logic [31:0] r_buf [16];          // block as little-endian words
    logic [63:0] r_cnt;
    logic [63:0] r_len;                // latched length for padding
    logic [5:0]  r_pos;
    logic [31:0] r_h [4];
    logic [31:0] r_v [4];
    logic [5:0]  r_step;               // 0..47 during compression, then 48
    logic        r_busy;
    logic        r_done;
    logic [31:0] r_dw;
    logic [1:0]  r_wi;
    logic        r_lw;

    logic [7:0]  wbyte;
    logic [1:0]  rnd;
    logic [3:0]  si;
    logic [1:0]  t;
    logic [31:0] b, c, d, f, m, k, sum;
    logic [2:0]  lsel;

    // byte source
    assign lsel = r_pos[2:0];
    always_comb begin
        case (i_cmd.bsel)
            BSEL_DATA: wbyte = i_data_byte;
            BSEL_PAD:  wbyte = PAD_BYTE;
            BSEL_ZERO: wbyte = 8'h00;
            default:   wbyte = r_len[{lsel, 3'b000} +: 8];
        endcase
    end

    // round step
    assign rnd = (r_step < 6'd16) ? 2'd0 : ((r_step < 6'd32) ? 2'd1 : 2'd2);
    assign si  = r_step[3:0];
    assign t   = 2'd0 - si[1:0];
    assign b   = r_v[t + 2'd1];
    assign c   = r_v[t + 2'd2];
    assign d   = r_v[t + 2'd3];
    assign m   = r_buf[msg_idx(rnd, si)];
    always_comb begin
        case (rnd)
            2'd0: begin f = (b & c) | (~b & d); k = 32'd0; end
            2'd1: begin f = (b & c) | (b & d) | (c & d); k = K2; end
            default: begin f = b ^ c ^ d; k = K3; end
        endcase
    end
    assign sum = r_v[t] + f + m + k;

    // buffer and counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en)
            r_buf[r_pos[5:2]][{r_pos[1:0], 3'b000} +: 8] <= wbyte;
        if (i_cmd.wr_en && i_cmd.bsel == BSEL_PAD) r_len <= r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 64'd0;
            r_pos  <= 6'd0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 6'd0;
            r_h[0] <= IV0; r_h[1] <= IV1; r_h[2] <= IV2; r_h[3] <= IV3;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.wr_en) r_pos <= r_pos + 6'd1;
            if (i_cmd.cnt_add) r_cnt <= r_cnt + 64'd8;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_step <= 6'd0;
                for (int j = 0; j < 4; j++) r_v[j] <= r_h[j];
            end else if (r_busy) begin
                r_v[t] <= rotl(sum, shift_amt(rnd, si[1:0]));
                if (r_step == 6'd47) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 6'd1;
            end
            if (r_done)
                for (int j = 0; j < 4; j++) r_h[j] <= r_h[j] + r_v[j];
            if (i_cmd.load_iv) begin
                r_h[0] <= IV0; r_h[1] <= IV1; r_h[2] <= IV2; r_h[3] <= IV3;
                r_cnt  <= 64'd0;
                r_pos  <= 6'd0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_dw <= r_h[i_cmd.out_idx];
            r_wi <= i_cmd.out_idx;
            r_lw <= (i_cmd.out_idx == 2'd3);
        end
    end

    assign o_status.busy = r_busy || r_done;
    assign o_status.done = r_done;
    assign o_status.pos  = r_pos;
    assign o_digest_word = r_dw;
    assign o_word_index  = r_wi;
    assign o_last_word   = r_lw;

endmodule

[hdl/md4_hash_engine_unit.sv]
// ============================================================================
// MD4 hash engine
// Streaming MD4 digest over bytes with padding and four-word output.
// ============================================================================
// An absorb item is taken whenever the engine is idle; the 64th byte of a
// block starts a 48-step compression on one shared round unit, and that item
// holds the input off until the compression is done. A finish item writes the
// padding one byte per cycle (one or two blocks, each compressed in turn) and
// then delivers four digest items, word 0 first; no input is taken until the last is gone.
`include "md4_hash_engine_unit_macros.svh"
module md4_hash_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);
    import md4_pkg::*;

    t_cmd    cmd;
    t_status status;

    md4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_command   (i_command),
        .o_stall     (o_stall),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    md4_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_data_byte),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    // no byte written while the round unit runs
    `MD4_ASSERT_IMPL(a_nowr_busy, i_clk, i_rst_n, !(cmd.wr_en && status.busy && !status.done), "buffer write during compression")
    // last word flag tracks index
    `MD4_ASSERT_IMPL(a_last, i_clk, i_rst_n, !o_valid || (o_last_word == (o_word_index == 2'd3)), "last_word mismatch")
    // output pending holds the input off
    `MD4_ASSERT_NEXT(a_stall, i_clk, i_rst_n, o_valid && i_stall, o_stall, "input taken while result waits")

endmodule

[tb/md4_digest_checker.sv]
// ----------------------------------------------------------------------------
// MD4 digest checker
// Watches the byte and digest channels, computes the expected digest words
// on each finish item and compares them with the words the engine delivers.
// ----------------------------------------------------------------------------
module md4_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_digest_word,
    input  logic [1:0]  i_word_index,
    input  logic        i_last_word,
    output int          o_fail_count,
    output int          o_pending
);
    import md4_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } t_digest_item;

    logic [31:0]  chain [4];
    logic [7:0]   block_bytes [64];
    logic [63:0]  msg_bits;
    t_digest_item digest_q [$];

    assign o_pending = digest_q.size();

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    // one 48-step compression of the current block into the chain
    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] v [4];
        logic [31:0] b, c, d, f, m, k;
        int t, s, idx;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i+3], block_bytes[4*i+2],
                    block_bytes[4*i+1], block_bytes[4*i]};
        for (int i = 0; i < 4; i++) v[i] = chain[i];
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 16; i++) begin
                t = (4 - (i % 4)) % 4;
                b = v[(t+1)%4];
                c = v[(t+2)%4];
                d = v[(t+3)%4];
                if (r == 0) begin
                    f = (b & c) | (~b & d);
                    idx = i;
                    k = 32'h0;
                    s = (i%4 == 0) ? 3 : (i%4 == 1) ? 7 : (i%4 == 2) ? 11 : 19;
                end else if (r == 1) begin
                    f = (b & c) | (b & d) | (c & d);
                    idx = ((i % 4) * 4) + (i / 4);
                    k = K2;
                    s = (i%4 == 0) ? 3 : (i%4 == 1) ? 5 : (i%4 == 2) ? 9 : 13;
                end else begin
                    f = b ^ c ^ d;
                    // bit-reversed word order
                    idx = ((i & 1) << 3) | ((i & 2) << 1) | ((i & 4) >> 1) | ((i & 8) >> 3);
                    k = K3;
                    s = (i%4 == 0) ? 3 : (i%4 == 1) ? 9 : (i%4 == 2) ? 11 : 15;
                end
                m = w[idx];
                v[t] = rot_left(v[t] + f + m + k, s);
            end
        end
        for (int i = 0; i < 4; i++) chain[i] = chain[i] + v[i];
    endtask

    task automatic push_byte(input logic [7:0] data, inout int pos);
        block_bytes[pos] = data;
        pos = (pos + 1) % 64;
        if (pos == 0) compress_block();
    endtask

    task automatic load_initial();
        chain[0] = IV0; chain[1] = IV1; chain[2] = IV2; chain[3] = IV3;
        msg_bits = 64'h0;
    endtask

    task automatic absorb_item(input logic cmd, input logic [7:0] data);
        int pos;
        logic [63:0] len;
        t_digest_item it;
        pos = int'(msg_bits[8:3]);
        len = msg_bits;
        if (cmd == CMD_ABSORB) begin
            msg_bits = msg_bits + 64'd8;
            push_byte(data, pos);
        end else begin
            push_byte(PAD_BYTE, pos);
            while (pos != int'(LEN_POS)) push_byte(8'h00, pos);
            for (int i = 0; i < 8; i++) push_byte(len[8*i +: 8], pos);
            for (int i = 0; i < 4; i++) begin
                it.word = chain[i];
                it.index = 2'(i);
                it.last = (i == 3);
                digest_q.push_back(it);
            end
            load_initial();
        end
    endtask

    always @(posedge i_clk) begin
        t_digest_item exp_item;
        if (!i_rst_n) begin
            load_initial();
            digest_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_valid && !i_stall) absorb_item(i_command, i_data_byte);
            if (i_out_valid && !i_out_stall) begin
                if (digest_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected digest word %h index %0d",
                                 i_digest_word, i_word_index);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_item = digest_q.pop_front();
                    if (exp_item !== {i_digest_word, i_word_index, i_last_word}) begin
                        if (o_fail_count < 10)
                            $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                     exp_item.word, exp_item.index, exp_item.last,
                                     i_digest_word, i_word_index, i_last_word);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[tb/md4_hash_engine_unit_test.sv]
// ----------------------------------------------------------------------------
// MD4 hash engine testbench
// Feeds directed and random messages byte by byte, with random idle and
// stall bursts and one long output hold-off; the checker judges the digests.
// ----------------------------------------------------------------------------
module md4_hash_engine_unit_test;
    import md4_pkg::*;

    localparam int TOTAL_ITEMS = 280;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_command = CMD_ABSORB;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [1:0]  o_word_index;
    logic        o_last_word;
    int          fail_count;
    int          pending_words;
    int          idle_cycles = 0;
    bit          quiet_phase = 1'b0;
    bit          hold_request = 1'b0;

    always #2 i_clk = ~i_clk;

    md4_hash_engine_unit dut (.*);

    md4_digest_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall(o_stall),
        .i_command(i_command), .i_data_byte(i_data_byte),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_digest_word(o_digest_word), .i_word_index(o_word_index),
        .i_last_word(o_last_word),
        .o_fail_count(fail_count), .o_pending(pending_words)
    );

    // send one item, holding it until the engine takes it
    task automatic send_item(input logic cmd, input logic [7:0] data);
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_data_byte <= data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_message(input int len, input bit pattern);
        for (int i = 0; i < len; i++)
            send_item(CMD_ABSORB, pattern ? 8'(i * 37 + 5) : 8'($urandom_range(0, 255)));
        send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // output side: random stall bursts, plus one long hold-off on request
    always begin
        @(posedge i_clk);
        if (hold_request) begin
            i_stall <= 1'b1;
            repeat (400) @(posedge i_clk);
            i_stall <= 1'b0;
            hold_request = 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            i_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
            i_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("md4_hash_engine_unit test failed");
            $finish;
        end
    end

    initial begin
        int sent;
        int len;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty message, single byte extremes, short messages
        send_message(0, 1'b0);
        send_item(CMD_ABSORB, 8'h00);
        send_item(CMD_FINISH, 8'hff);
        send_item(CMD_ABSORB, 8'hff);
        send_item(CMD_FINISH, 8'h00);
        send_item(CMD_ABSORB, 8'h55);
        send_item(CMD_ABSORB, 8'haa);
        send_item(CMD_FINISH, 8'h00);
        send_message(3, 1'b1);
        // long hold-off on the output while a finish is pending
        hold_request = 1'b1;
        send_message(1, 1'b0);
        send_message(1, 1'b0);
        sent = 15;
        // random messages, many around the 55/56/64 padding boundaries
        while (sent < TOTAL_ITEMS) begin
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(54, 57);
                2: len = $urandom_range(63, 65);
                default: len = $urandom_range(0, 130);
            endcase
            if (len > TOTAL_ITEMS - sent - 1) len = TOTAL_ITEMS - sent - 1;
            if (sent > TOTAL_ITEMS - 60) quiet_phase = 1'b1;
            send_message(len, 1'b0);
            sent += len + 1;
        end
        i_valid <= 1'b0;
        while (pending_words != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("md4_hash_engine_unit test passed");
        else
            $display("md4_hash_engine_unit test failed");
        $finish;
    end

endmodule
